// File: rtl/wsng_pkg.sv
// shared types and constants of the windowed smoothing noise gate
package wsng_pkg;

  localparam int SAMPLE_W = 16;
  localparam int THRESH_W = 15;
  localparam int QUO_W    = 16;
  localparam int WEIGHT_W = 17;

  // register map, index is paddr[2]
  localparam logic REG_GATE_THRESHOLD = 1'b0;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd328;

  // gate: a*327680 < t*(360448 - a)
  localparam int GATE_RHS_BASE = 360448;

  // clamp limits, about +-0.7 full scale
  localparam logic [QUO_W-1:0] OUT_POS_MAX = 16'd22937;
  localparam logic [QUO_W-1:0] OUT_NEG_MAX = 16'd22938;

  typedef struct packed {
    logic push;   // new sample into the window
    logic skip;   // empty slot into the window
    logic clear;  // drop all held samples
    logic rd_en;  // read one slot
  } win_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/wsng_if.sv
// stream channels of the noise gate
interface wsng_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_sample;
  logic               frame_end;
  modport source (output valid, in_sample, frame_end, input ready);
  modport sink (input valid, in_sample, frame_end, output ready);
endinterface

interface wsng_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;
  logic               run_last;
  logic               frame_last;
  modport source (output valid, out_sample, run_last, frame_last, input ready);
  modport sink (input valid, out_sample, run_last, frame_last, output ready);
endinterface

// File: rtl/windowed_smoothing_noise_gate.sv
// top level of the windowed smoothing noise gate
//
//   channel   dir  signals                                   transfer
//   audio     in   valid ready in_sample frame_end            valid & ready
//   smoothed  out  valid ready out_sample run_last frame_last valid & ready
//   apb       in   psel penable pwrite paddr pwdata prdata    psel & penable & pwrite
//
// one result, with the output free, takes these steps: take the sample or shift the window,
// one check, one pass of the shared multiplier over every window slot through the registered
// window read and the product register into the accumulators, the divider, then multiply,
// gate and emit; a sample with no centre yet leaves after the check
// a frame end adds up to HALF_WIDTH further results, one per window shift
// audio.ready is high only in idle; one item is worked at a time
// reset is synchronous; valid bits clear at once, no clearing pass
// a stalled result holds in the output register while the next sample is taken
module windowed_smoothing_noise_gate #(
  parameter int HALF_WIDTH = 5
) (
  input  logic         clk,
  input  logic         rst,
  wsng_in_if.sink      audio,
  wsng_out_if.source   smoothed,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import wsng_pkg::*;

  localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
  localparam int PTR_W   = $clog2(WIN_LEN);
  localparam int CNT_W   = $clog2(WIN_LEN + 1);
  localparam int D_W     = $clog2(HALF_WIDTH + 1);
  localparam int SHF_W   = $clog2(HALF_WIDTH + 1);
  localparam int PROD_W  = 38;
  localparam int NUM_W   = PROD_W + $clog2(WIN_LEN);
  localparam int DEN_W   = WEIGHT_W + $clog2(WIN_LEN);
  localparam int DVD_W   = NUM_W + 1;
  localparam int DSR_W   = DEN_W + 1;
  localparam int LHS_W   = 35;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_GMUL  = 3'd4;
  localparam logic [2:0] S_GATE  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_SHIFT = 3'd7;

  // terms of the alternating series for exp(-1/HALF_WIDTH) in Q30
  // fourteen terms run the series out even at HALF_WIDTH 1
  localparam longint ST0  = longint'(1) << 30;
  localparam longint ST1  = ST0 / (1 * HALF_WIDTH);
  localparam longint ST2  = ST1 / (2 * HALF_WIDTH);
  localparam longint ST3  = ST2 / (3 * HALF_WIDTH);
  localparam longint ST4  = ST3 / (4 * HALF_WIDTH);
  localparam longint ST5  = ST4 / (5 * HALF_WIDTH);
  localparam longint ST6  = ST5 / (6 * HALF_WIDTH);
  localparam longint ST7  = ST6 / (7 * HALF_WIDTH);
  localparam longint ST8  = ST7 / (8 * HALF_WIDTH);
  localparam longint ST9  = ST8 / (9 * HALF_WIDTH);
  localparam longint ST10 = ST9 / (10 * HALF_WIDTH);
  localparam longint ST11 = ST10 / (11 * HALF_WIDTH);
  localparam longint ST12 = ST11 / (12 * HALF_WIDTH);
  localparam longint ST13 = ST12 / (13 * HALF_WIDTH);
  localparam longint R_Q30 = ST0 - ST1 + ST2 - ST3 + ST4 - ST5 + ST6 - ST7
                           + ST8 - ST9 + ST10 - ST11 + ST12 - ST13;

  // weight for offset d, Q16
  function automatic logic [WEIGHT_W-1:0] weight_of(input int d);
    longint w;
    w = 65536;
    for (int i = 1; i <= 16; i++) begin
      if (i <= d) w = (w * R_Q30 + (longint'(1) << 29)) >>> 30;
    end
    return WEIGHT_W'(w);
  endfunction

  logic [WEIGHT_W-1:0] weight_tab [HALF_WIDTH+1];

  for (genvar g = 0; g <= HALF_WIDTH; g++) begin : g_weight
    localparam logic [WEIGHT_W-1:0] WV = weight_of(g);
    assign weight_tab[g] = WV;
  end

  // configuration register
  logic [THRESH_W-1:0] thresh;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GATE_THRESHOLD) ? {17'b0, thresh} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_GATE_THRESHOLD) begin
      thresh <= pwdata[THRESH_W-1:0];
    end
  end

  // sequencer and datapath state
  logic [2:0]                state;
  logic [2:0]                state_next;
  logic                      fend;
  logic [SHF_W-1:0]          shifts;
  logic [CNT_W-1:0]          iss_cnt;
  logic                      p1;
  logic                      p2;
  logic [D_W-1:0]            d1;
  logic [D_W-1:0]            offset;
  logic                      v2;
  logic [WEIGHT_W-1:0]       w2;
  logic signed [NUM_W-1:0]   num;
  logic [DEN_W-1:0]          den;
  logic signed [PROD_W-1:0]  prod;
  logic signed [17:0]        mul_a;
  logic signed [19:0]        mul_b;
  logic [QUO_W-1:0]          a_q;
  logic                      neg;
  logic signed [SAMPLE_W-1:0] res;
  logic signed [SAMPLE_W-1:0] res_next;
  logic [NUM_W-1:0]          mag;
  logic [DVD_W-1:0]          dvd;
  logic [DSR_W-1:0]          dsr;
  logic [LHS_W-1:0]          lhs;
  logic [QUO_W-1:0]          lim;
  logic                      gated;
  logic                      issuing;
  logic                      mac_done;
  logic                      flush_more;
  logic                      advance;
  logic                      emit_go;
  logic                      accept;

  win_cmd_t                  win_cmd;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                      rd_valid;
  logic                      centre_valid;

  div_stat_t                 div_stat;
  logic [QUO_W-1:0]          quotient;

  // output register
  logic                      out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                      out_run_last;
  logic                      out_frame_last;

  assign accept     = audio.valid && audio.ready;
  assign audio.ready = (state == S_IDLE);
  assign issuing    = (state == S_MAC) && (iss_cnt < CNT_W'(WIN_LEN));
  assign mac_done   = (state == S_MAC) && (iss_cnt == CNT_W'(WIN_LEN)) && !p1 && !p2;
  assign flush_more = fend && (shifts != SHF_W'(HALF_WIDTH));
  assign emit_go    = (state == S_EMIT) && (!out_valid || smoothed.ready);
  // leave the current centre: either no result or the result is out
  assign advance    = ((state == S_CHECK) && !centre_valid) || emit_go;

  // distance of the issued slot from the centre
  always_comb begin
    if (iss_cnt >= CNT_W'(HALF_WIDTH)) offset = D_W'(iss_cnt - CNT_W'(HALF_WIDTH));
    else                               offset = D_W'(CNT_W'(HALF_WIDTH) - iss_cnt);
  end

  always_comb begin
    win_cmd.push  = accept;
    win_cmd.skip  = (state == S_SHIFT);
    win_cmd.clear = advance && !flush_more && fend;
    win_cmd.rd_en = issuing;
  end

  wsng_window #(
    .HALF_WIDTH (HALF_WIDTH)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .cmd          (win_cmd),
    .wdata        (audio.in_sample),
    .rd_k         (iss_cnt[PTR_W-1:0]),
    .rd_data      (rd_data),
    .rd_valid     (rd_valid),
    .centre_valid (centre_valid)
  );

  // rounded average: (2|num| + den) / (2 den)
  always_comb begin
    mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dvd = {mag, 1'b0} + DVD_W'(den);
    dsr = {den, 1'b0};
  end

  wsng_div #(
    .DVD_W (DVD_W),
    .DSR_W (DSR_W),
    .Q_W   (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mac_done),
    .dividend (dvd),
    .divisor  (dsr),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // the one multiplier: sample times weight, then threshold times gate slope
  always_comb begin
    if (state == S_GMUL) begin
      mul_a = $signed({3'b0, thresh});
      mul_b = $signed(20'(GATE_RHS_BASE) - {4'b0, a_q});
    end else begin
      mul_a = 18'(rd_data);
      mul_b = $signed({3'b0, weight_tab[d1]});
    end
  end

  // gate and clamp
  always_comb begin
    lhs   = (LHS_W'(a_q) << 18) + (LHS_W'(a_q) << 16);
    gated = {3'b0, lhs} < $unsigned(prod);
    if (neg) lim = (a_q > OUT_NEG_MAX) ? OUT_NEG_MAX : a_q;
    else     lim = (a_q > OUT_POS_MAX) ? OUT_POS_MAX : a_q;
    if (gated)    res_next = '0;
    else if (neg) res_next = -$signed(lim);
    else          res_next = $signed(lim);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_CHECK;
      S_CHECK: begin
        if (centre_valid)    state_next = S_MAC;
        else if (flush_more) state_next = S_SHIFT;
        else                 state_next = S_IDLE;
      end
      S_MAC:   if (mac_done) state_next = S_DIV;
      S_DIV:   if (div_stat.done) state_next = S_GMUL;
      S_GMUL:  state_next = S_GATE;
      S_GATE:  state_next = S_EMIT;
      S_EMIT: begin
        if (emit_go) state_next = flush_more ? S_SHIFT : S_IDLE;
      end
      S_SHIFT: state_next = S_CHECK;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fend    <= 1'b0;
      shifts  <= '0;
      iss_cnt <= '0;
      p1      <= 1'b0;
      p2      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fend   <= audio.frame_end;
        shifts <= '0;
      end
      if (state == S_SHIFT) shifts <= shifts + 1'b1;
      if (state == S_CHECK) begin
        iss_cnt <= '0;
        p1      <= 1'b0;
        p2      <= 1'b0;
      end else if (state == S_MAC) begin
        if (issuing) iss_cnt <= iss_cnt + 1'b1;
        p1 <= issuing;
        p2 <= p1;
      end
    end
  end

  // accumulators and product pipeline
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      num <= '0;
      den <= '0;
    end else if (state == S_MAC && p2 && v2) begin
      num <= num + NUM_W'(prod);
      den <= den + DEN_W'(w2);
    end
    if (issuing) d1 <= offset;
    if ((state == S_MAC && p1) || state == S_GMUL) prod <= mul_a * mul_b;
    if (state == S_MAC && p1) begin
      v2 <= rd_valid;
      w2 <= weight_tab[d1];
    end
    if (state == S_DIV && div_stat.done) begin
      a_q <= quotient;
      neg <= num[NUM_W-1];
    end
    if (state == S_GATE) res <= res_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (smoothed.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_sample     <= res;
      out_run_last   <= !flush_more;
      out_frame_last <= fend && !flush_more;
    end
  end

  assign smoothed.valid      = out_valid;
  assign smoothed.out_sample = out_sample;
  assign smoothed.run_last   = out_run_last;
  assign smoothed.frame_last = out_frame_last;

endmodule

// File: rtl/wsng_window.sv
// circular sample window with per-slot valid bits and a registered read port
module wsng_window #(
  parameter int HALF_WIDTH = 5
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  wsng_pkg::win_cmd_t                      cmd,
  input  logic signed [15:0]                      wdata,
  input  logic [$clog2(2*HALF_WIDTH+1)-1:0]       rd_k,
  output logic signed [15:0]                      rd_data,
  output logic                                    rd_valid,
  output logic                                    centre_valid
);
  import wsng_pkg::*;

  localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
  localparam int PTR_W   = $clog2(WIN_LEN);

  logic signed [SAMPLE_W-1:0] mem [WIN_LEN];
  logic [WIN_LEN-1:0]         valid;
  logic [PTR_W-1:0]           ptr;
  logic [PTR_W-1:0]           ptr_inc;
  logic [PTR_W-1:0]           rd_addr;
  logic [PTR_W-1:0]           centre_addr;
  logic [PTR_W:0]             wrap_rd;
  logic [PTR_W:0]             wrap_centre;

  assign ptr_inc = (ptr == PTR_W'(WIN_LEN - 1)) ? '0 : ptr + 1'b1;

  // slot k back from the newest, modulo the window length
  always_comb begin
    wrap_rd     = {1'b0, ptr} + (PTR_W+1)'(WIN_LEN) - {1'b0, rd_k};
    wrap_centre = {1'b0, ptr} + (PTR_W+1)'(WIN_LEN) - (PTR_W+1)'(HALF_WIDTH);
    rd_addr     = (ptr >= rd_k) ? ptr - rd_k : wrap_rd[PTR_W-1:0];
    centre_addr = (ptr >= PTR_W'(HALF_WIDTH)) ? ptr - PTR_W'(HALF_WIDTH)
                                              : wrap_centre[PTR_W-1:0];
  end

  assign centre_valid = valid[centre_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      valid <= '0;
    end else if (cmd.clear) begin
      valid <= '0;
    end else if (cmd.push) begin
      ptr            <= ptr_inc;
      valid[ptr_inc] <= 1'b1;
    end else if (cmd.skip) begin
      ptr            <= ptr_inc;
      valid[ptr_inc] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[ptr_inc] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

// File: rtl/wsng_div.sv
// restoring divider, one quotient bit per cycle
module wsng_div #(
  parameter int DVD_W = 44,
  parameter int DSR_W = 22,
  parameter int Q_W   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DVD_W-1:0]       dividend,
  input  logic [DSR_W-1:0]       divisor,
  output wsng_pkg::div_stat_t    stat,
  output logic [Q_W-1:0]         quotient
);
  import wsng_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [Q_W-1:0]   low;
  logic [CNT_W-1:0] cnt;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             fits;
  logic             busy;
  logic             done;

  // quotient fits Q_W bits, so the upper dividend part is below the divisor
  assign trial = {rem, low[Q_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= DSR_W'(dividend[DVD_W-1:Q_W]);
      low      <= dividend[Q_W-1:0];
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      low      <= {low[Q_W-2:0], 1'b0};
      quotient <= {quotient[Q_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/wsng_checker.sv
// port checks of the noise gate and their binding to the top level
module wsng_checker (
  input logic               clk,
  input logic               rst,
  input logic               a_valid,
  input logic               a_ready,
  input logic               r_valid,
  input logic               r_ready,
  input logic signed [15:0] r_sample,
  input logic               r_run_last,
  input logic               r_frame_last
);

  // one sample in flight: ready drops right after a transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_ready |=> !a_ready)
    else $error("input taken while a sample is still in work");

  // results stay inside the clamp range
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> (r_sample >= -16'sd22938) && (r_sample <= 16'sd22937))
    else $error("result outside the clamp range");

  // a frame's final result also closes its item
  a_frame_closes_run: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_frame_last |-> r_run_last)
    else $error("frame_last without run_last");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_sample) && $stable(r_run_last)
      && $stable(r_frame_last))
    else $error("stalled result changed");

endmodule

bind windowed_smoothing_noise_gate wsng_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .a_valid      (audio.valid),
  .a_ready      (audio.ready),
  .r_valid      (smoothed.valid),
  .r_ready      (smoothed.ready),
  .r_sample     (smoothed.out_sample),
  .r_run_last   (smoothed.run_last),
  .r_frame_last (smoothed.frame_last)
);

// File: test/smoothing_checker.sv
// checker for the noise gate: predicts smoothed samples and compares transfers
`timescale 1ns / 1ps

module smoothing_checker #(
  parameter int HALF = 5
) (
  input  logic        clk,
  input  logic        rst,
  wsng_in_if          audio,
  wsng_out_if         smoothed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);
  import wsng_pkg::*;

  localparam int SPAN = 2 * HALF + 1;
  localparam longint GATE_LHS_SCALE = 327680;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       run_last;
    logic                       frame_last;
  } smooth_item_t;

  smooth_item_t               smooth_q[$];
  longint                     weight [0:HALF];
  logic signed [SAMPLE_W-1:0] window [0:SPAN-1];
  logic [SPAN-1:0]            held;
  logic [THRESH_W-1:0]        threshold;

  // exp(-d/HALF) weights in Q16, ratio from the alternating series in Q30
  initial begin
    longint ratio, term, k;
    ratio = 0;
    term  = longint'(1) <<< 30;
    k     = 0;
    while (term > 0) begin
      ratio += k[0] ? -term : term;
      k++;
      term = term / (k * HALF);
    end
    weight[0] = 65536;
    for (int d = 1; d <= HALF; d++)
      weight[d] = (weight[d-1] * ratio + (longint'(1) <<< 29)) >>> 30;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    errors = errors + 1;
  endtask

  // weighted average of the held slots around the centre, gated and clamped
  function automatic logic signed [SAMPLE_W-1:0] centre_level();
    longint num, den, mag, a, lim;
    int     offset;
    num = 0;
    den = 0;
    for (int k = 0; k < SPAN; k++) begin
      if (held[k]) begin
        offset = (k >= HALF) ? k - HALF : HALF - k;
        num += longint'(window[k]) * weight[offset];
        den += weight[offset];
      end
    end
    if (den <= 0) return '0;
    mag = (num < 0) ? -num : num;
    a   = (2 * mag + den) / (2 * den);
    if (a * GATE_LHS_SCALE < longint'(threshold) * (GATE_RHS_BASE - a)) return '0;
    lim = (num < 0) ? longint'(OUT_NEG_MAX) : longint'(OUT_POS_MAX);
    if (a > lim) a = lim;
    return SAMPLE_W'((num < 0) ? -a : a);
  endfunction

  task automatic shift_window(input logic signed [SAMPLE_W-1:0] s, input logic present);
    for (int k = SPAN - 1; k > 0; k--)
      window[k] = window[k-1];
    window[0] = present ? s : '0;
    held = {held[SPAN-2:0], present};
  endtask

  task automatic emit_centre();
    smooth_item_t item;
    if (held[HALF]) begin
      item.smp        = centre_level();
      item.run_last   = 1'b0;
      item.frame_last = 1'b0;
      smooth_q.push_back(item);
    end
  endtask

  task automatic predict(input logic signed [SAMPLE_W-1:0] s, input logic fend);
    int before_n;
    before_n = smooth_q.size();
    shift_window(s, 1'b1);
    emit_centre();
    if (fend) begin
      // flush the tail of the frame, then forget it
      repeat (HALF) begin
        shift_window('0, 1'b0);
        emit_centre();
      end
      for (int k = 0; k < SPAN; k++)
        window[k] = '0;
      held = '0;
      if (smooth_q.size() > before_n) smooth_q[smooth_q.size()-1].frame_last = 1'b1;
    end
    if (smooth_q.size() > before_n) smooth_q[smooth_q.size()-1].run_last = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    smooth_item_t want;
    if (rst) begin
      smooth_q.delete();
      for (int k = 0; k < SPAN; k++)
        window[k] = '0;
      held      = '0;
      threshold = THRESH_RESET;
      errors    = 0;
    end else begin
      if (smoothed.valid && smoothed.ready) begin
        if (smooth_q.size() == 0) begin
          report_mismatch("result with nothing expected, out_sample",
                          int'(smoothed.out_sample), 0);
        end else begin
          want = smooth_q.pop_front();
          if (smoothed.out_sample !== want.smp)
            report_mismatch("out_sample", int'(smoothed.out_sample), int'(want.smp));
          if (smoothed.run_last !== want.run_last)
            report_mismatch("run_last", int'(smoothed.run_last), int'(want.run_last));
          if (smoothed.frame_last !== want.frame_last)
            report_mismatch("frame_last", int'(smoothed.frame_last), int'(want.frame_last));
        end
      end
      if (audio.valid && audio.ready)
        predict(audio.in_sample, audio.frame_end);
      if (psel && penable && pwrite && pready && paddr[2] == REG_GATE_THRESHOLD)
        threshold = pwdata[THRESH_W-1:0];
    end
    pending = smooth_q.size();
  end

endmodule

// File: test/testbench.sv
// top of the noise gate testbench: clock, reset, stimulus, pacing and verdict
`timescale 1ns / 1ps

module testbench;
  import wsng_pkg::*;

  localparam int HALF = 5;
  // cycles for one result: multiplier pass over the window plus the divider
  localparam int RESULT_CYCLES = 2 * HALF + 26;
  // quiet time before a register write, covers an item that yields nothing
  localparam int SETTLE_CYCLES = 4 * RESULT_CYCLES;
  // trailing watch for stray results, a full frame-end flush
  localparam int TAIL_CYCLES = (HALF + 1) * RESULT_CYCLES;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 62;

  localparam logic [2:0] ADDR_THRESH = {REG_GATE_THRESHOLD, 2'b00};
  // index one past the register list, the block must ignore it
  localparam logic [2:0] ADDR_UNUSED = {~REG_GATE_THRESHOLD, 2'b00};

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int                  errors;
  int                  pending;
  logic                in_fire = 1'b0;
  logic                quiet = 1'b0;
  logic [THRESH_W-1:0] cur_thr = THRESH_RESET;

  // directed frame of extreme and small values
  logic signed [SAMPLE_W-1:0] mixed_frame [0:12] = '{
    16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd100, -16'sd100,
    16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sd5
  };

  wsng_in_if  audio ();
  wsng_out_if smoothed ();

  windowed_smoothing_noise_gate #(
    .HALF_WIDTH (HALF)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .audio    (audio),
    .smoothed (smoothed),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  smoothing_checker #(
    .HALF (HALF)
  ) u_check (
    .clk      (clk),
    .rst      (rst),
    .audio    (audio),
    .smoothed (smoothed),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // remembers whether the last rising edge moved a sample in
  always @(posedge clk) in_fire <= audio.valid && audio.ready;

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // sink pacing: random stall bursts, long open stretches, none at the end
  initial begin : sink_pacing
    int hold;
    hold = 0;
    smoothed.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        smoothed.ready = 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 2) == 0) begin
        smoothed.ready = 1'b0;
        hold = $urandom_range(1, 18) - 1;
      end else begin
        smoothed.ready = 1'b1;
        hold = $urandom_range(1, 30) - 1;
      end
    end
  end

  // one sample transfer; valid stays up so a back-to-back sample needs no dip
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic fend);
    audio.in_sample = s;
    audio.frame_end = fend;
    audio.valid     = 1'b1;
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      audio.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic drain();
    audio.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // setup cycle then access cycle; pready is tied high by the block
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // full range, values around the gate edge, and clamp neighbors
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int mag;
    case ($urandom_range(0, 3))
      0, 1: return SAMPLE_W'($urandom());
      2: begin
        mag = $urandom_range(0, 2 * int'(cur_thr) + 64);
        if (mag > 32767) mag = 32767;
        return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sd22938;
          default: return -16'sd22939;
        endcase
      end
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_sample(pick_sample(), i == len - 1);
      sender_gap();
    end
  endtask

  initial begin : stimulus
    int count;
    int len;
    logic [THRESH_W-1:0] thr;
    logic paused;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    audio.valid = 1'b0;
    audio.in_sample = '0;
    audio.frame_end = 1'b0;
    paused = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed part, reset threshold
    // single-sample frame: the centre is the only held slot
    send_sample(16'sh7FFF, 1'b1);
    sender_gap();
    // short frame of the most negative value
    for (int i = 0; i < 3; i++) begin
      send_sample(16'sh8000, i == 2);
      sender_gap();
    end
    // frame longer than the window, steady output then a full flush
    for (int i = 0; i < 13; i++) begin
      send_sample(mixed_frame[i], i == 12);
      sender_gap();
    end
    settle();
    // write to a missing register, then threshold zero with junk upper bits
    apb_write(ADDR_UNUSED, 32'h0000_7FFF);
    apb_write(ADDR_THRESH, 32'hFFFF_8000);
    cur_thr = '0;
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b1);

    // random phases, each under its own threshold
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: thr = 15'h7FFF;
        1: thr = THRESH_RESET;
        3: thr = 15'd1000;
        4: thr = 15'($urandom_range(0, 200));
        default: thr = 15'($urandom_range(0, 32767));
      endcase
      if (ph == 2) apb_write(ADDR_UNUSED, $urandom());
      apb_write(ADDR_THRESH, ($urandom() & 32'hFFFF_8000) | 32'(thr));
      cur_thr = thr;
      // last phase runs with no idling on either side
      if (ph == PHASES - 1) quiet = 1'b1;
      count = 0;
      while (count < PHASE_ITEMS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 48) : $urandom_range(1, 20);
        send_frame(len);
        count += len;
        // sender holds back until every result is out
        if (!quiet && ((ph == 2 && !paused) || $urandom_range(0, 15) == 0)) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
